/* hdl/cau_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit: request and
// result layouts, operation and status codes, and the CORDIC table and constants.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DW           = 16;  // operand and result width
  localparam int FB           = 12;  // fraction bits
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD        = 8;   // CORDIC guard bits on the vector

  // Divider geometry.
  localparam int NUM_W   = 2 * DW + 1;           // signed dividend
  localparam int DEN_W   = 2 * DW;               // unsigned divisor
  localparam int QB      = DW + 1;               // quotient bits kept
  localparam int REM_W   = NUM_W - 1 + FB;       // scaled dividend magnitude
  localparam int DIV_LAT = QB + 2;

  // CORDIC geometry.
  localparam int XW       = DW + GUARD + 4;      // vector width
  localparam int ZW       = 35;                  // angle width, Q5.30 radians
  localparam int MSPLIT   = 21;
  localparam int GAIN_SH  = 30 + GUARD - MSPLIT;
  localparam int ZSH      = 30 - FB;
  localparam int CORD_LAT = CORDIC_STEPS + 2;

  localparam logic [29:0]        INV_GAIN    = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;
  localparam logic [2:0] OP_MOD  = 3'd6;
  localparam logic [2:0] OP_ARG  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [2:0]           kind;
    logic signed [DW-1:0] a_real;
    logic signed [DW-1:0] a_imag;
    logic signed [DW-1:0] b_real;
    logic signed [DW-1:0] b_imag;
  } cau_req_t;

  typedef struct packed {
    logic signed [DW-1:0] res_real;
    logic signed [DW-1:0] res_imag;
    logic [1:0]           status;
  } cau_rsp_t;

endpackage
`default_nettype wire

/* hdl/cau_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider: saturated fixed-point quotient of a signed
// dividend by an unsigned divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
  input  logic                    clk,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [DW-1:0]    quo,
  output logic                    sat,
  output logic                    dz
);

  localparam int CMP_W = DEN_W + QB;
  localparam logic [QB-1:0] LIM_POS = {1'b0, MAXV};
  localparam logic [QB-1:0] LIM_NEG = {1'b0, MAXV} + QB'(1);

  logic [REM_W-1:0] rem   [QB+1];
  logic [QB-1:0]    q     [QB+1];
  logic [DEN_W-1:0] den_p [QB+1];
  logic             neg_p [QB+1];
  logic             ovf_p [QB+1];
  logic             dz_p  [QB+1];

  logic signed [NUM_W-1:0] num_abs;
  logic [REM_W-1:0]        scaled;

  assign num_abs = num[NUM_W-1] ? -num : num;
  assign scaled  = {num_abs[NUM_W-2:0], {FB{1'b0}}};

  // Entry stage: magnitude, and a check that the quotient fits in QB bits.
  always_ff @(posedge clk) begin
    rem[0]   <= scaled;
    q[0]     <= '0;
    den_p[0] <= den;
    neg_p[0] <= num[NUM_W-1];
    ovf_p[0] <= {{(CMP_W-REM_W){1'b0}}, scaled} >= {den, {QB{1'b0}}};
    dz_p[0]  <= (den == '0);
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [CMP_W-1:0] sh;
    logic             ge;
    assign sh = {{QB{1'b0}}, den_p[k]} << (QB - 1 - k);
    assign ge = {{(CMP_W-REM_W){1'b0}}, rem[k]} >= sh;

    always_ff @(posedge clk) begin
      rem[k+1]   <= ge ? rem[k] - sh[REM_W-1:0] : rem[k];
      q[k+1]     <= q[k] | (QB'(ge) << (QB - 1 - k));
      den_p[k+1] <= den_p[k];
      neg_p[k+1] <= neg_p[k];
      ovf_p[k+1] <= ovf_p[k];
      dz_p[k+1]  <= dz_p[k];
    end
  end

  logic [QB-1:0] lim;
  logic [QB-1:0] q_neg;

  assign lim   = neg_p[QB] ? LIM_NEG : LIM_POS;
  assign q_neg = -q[QB];

  always_ff @(posedge clk) begin
    dz <= dz_p[QB];
    if (ovf_p[QB] || q[QB] > lim) begin
      quo <= neg_p[QB] ? MINV : MAXV;
      sat <= 1'b1;
    end else begin
      quo <= neg_p[QB] ? q_neg[DW-1:0] : q[QB][DW-1:0];
      sat <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hdl/cau_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_cordic
// Pipelined vectoring CORDIC, one rotation per stage, followed by gain
// correction of the magnitude and rounding of the angle.
// ----------------------------------------------------------------------------
module cau_cordic import cau_pkg::*; (
  input  logic                 clk,
  input  logic signed [XW-1:0] x0,
  input  logic signed [XW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  input  logic                 byp,
  output logic [DW-1:0]        mod_val,
  output logic                 mod_sat,
  output logic [DW-1:0]        arg_val,
  output logic                 arg_sat
);

  localparam int N    = CORDIC_STEPS;
  localparam int UX_W = XW - 1;
  localparam int HI_W = UX_W - MSPLIT;
  localparam int PH_W = HI_W + 30;
  localparam int PL_W = MSPLIT + 30;
  localparam int AC_W = PH_W + 1;
  localparam int ZR_W = ZW - ZSH;
  localparam logic [AC_W-1:0]        ROUND_M = AC_W'(1) << (GAIN_SH - 1);
  localparam logic signed [ZW-1:0]   ROUND_Z = ZW'(1) << (ZSH - 1);
  localparam logic signed [ZR_W-1:0] ZR_MAX  = ZR_W'(2**(DW-1) - 1);
  localparam logic signed [ZR_W-1:0] ZR_MIN  = -ZR_MAX - ZR_W'(1);

  logic signed [XW-1:0] x [N+1];
  logic signed [XW-1:0] y [N+1];
  logic signed [ZW-1:0] z [N+1];
  logic                 b [N+1];

  assign x[0] = x0;
  assign y[0] = y0;
  assign z[0] = z0;
  assign b[0] = byp;

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = signed'(ZW'(ATAN_Q30[i]));

    always_ff @(posedge clk) begin
      b[i+1] <= b[i];
      if (y[i] > 0) begin
        x[i+1] <= x[i] + dx;
        y[i+1] <= y[i] - dy;
        z[i+1] <= b[i] ? z[i] : z[i] + at;
      end else begin
        x[i+1] <= x[i] - dx;
        y[i+1] <= y[i] + dy;
        z[i+1] <= b[i] ? z[i] : z[i] - at;
      end
    end
  end

  // The gain multiply is split at bit MSPLIT of the magnitude into two products.
  logic [UX_W-1:0]        ux;
  logic signed [ZW-1:0]   z_rnd;
  logic [PH_W-1:0]        ph;
  logic [PL_W-1:0]        pl;
  logic signed [ZR_W-1:0] zr;

  assign ux    = x[N][XW-1] ? '0 : x[N][UX_W-1:0];
  assign z_rnd = (z[N] + ROUND_Z) >>> ZSH;

  always_ff @(posedge clk) begin
    ph <= PH_W'(ux[UX_W-1:MSPLIT]) * PH_W'(INV_GAIN);
    pl <= PL_W'(ux[MSPLIT-1:0]) * PL_W'(INV_GAIN);
    zr <= z_rnd[ZR_W-1:0];
  end

  logic [AC_W-1:0] acc;
  logic [AC_W-1:0] acc_sh;

  assign acc    = AC_W'(ph) + ROUND_M + AC_W'(pl >> MSPLIT);
  assign acc_sh = acc >> GAIN_SH;

  always_ff @(posedge clk) begin
    if (acc_sh > AC_W'(MAXV)) begin
      mod_val <= MAXV;
      mod_sat <= 1'b1;
    end else begin
      mod_val <= acc_sh[DW-1:0];
      mod_sat <= 1'b0;
    end
    if (zr > ZR_MAX) begin
      arg_val <= MAXV;
      arg_sat <= 1'b1;
    end else if (zr < ZR_MIN) begin
      arg_val <= MINV;
      arg_sat <= 1'b1;
    end else begin
      arg_val <= zr[DW-1:0];
      arg_sat <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hdl/complex_arithmetic_unit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex-number ALU in signed Q4.12: add, subtract, multiply, divide,
// negate, conjugate, modulus and argument, with saturation status.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge where start is high and busy is low.
//   busy never rises, so one request can be taken in every cycle. The
//   request carries the operation code and both complex operands.
//   Each request gives exactly one result, shown on rsp for one cycle with
//   done high. Results leave in the order the requests came. The receiver
//   cannot stall the block.
//   The latency is set by the divider, which resolves one quotient bit per
//   stage over 17 stages; every operation is delayed to the same depth, so
//   throughput is one request per cycle for any mix of operations.
//   Modulus and argument use a 16-stage CORDIC; both return their value in
//   res_real with res_imag zero.
//   Status is 0 for a clean result, 1 when a part saturated, and 2 for a
//   division by zero, which returns zero in both parts.
//   Synchronous reset clears the valid bits, so no result appears for
//   requests in flight at reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cau_req_t req,
  output logic     done,
  output cau_rsp_t rsp
);

  localparam int WIDE_W = 2 * DW + 2;
  localparam int PAD    = DIV_LAT + 1 - CORD_LAT;
  localparam logic signed [WIDE_W-1:0] SMAX = WIDE_W'(2**(DW-1) - 1);
  localparam logic signed [WIDE_W-1:0] SMIN = -SMAX - WIDE_W'(1);

  typedef struct packed {
    logic [2:0] kind;
    cau_rsp_t   val;
  } cau_ctrl_t;

  // Returns {saturated, value}.
  function automatic logic [DW:0] sat_w(input logic signed [WIDE_W-1:0] v);
    logic [DW:0] r;
    if (v > SMAX) begin
      r = {1'b1, MAXV};
    end else if (v < SMIN) begin
      r = {1'b1, MINV};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // ---------------- stage 1: products, simple ops, CORDIC setup ----------
  logic signed [WIDE_W-1:0] ar_e, ai_e, br_e, bi_e;
  logic [DW:0]              sr, si;
  logic                     is_arg, ar_neg, ar_zero;
  logic signed [WIDE_W-1:0] x_src, y_src;
  logic signed [ZW-1:0]     z_init;

  assign ar_e    = WIDE_W'(req.a_real);
  assign ai_e    = WIDE_W'(req.a_imag);
  assign br_e    = WIDE_W'(req.b_real);
  assign bi_e    = WIDE_W'(req.b_imag);
  assign is_arg  = (req.kind == OP_ARG);
  assign ar_neg  = req.a_real[DW-1];
  assign ar_zero = (req.a_real == '0);
  assign x_src   = ar_neg ? -ar_e : ar_e;
  assign y_src   = (is_arg && ar_neg) ? -ai_e : ai_e;

  always_comb begin
    unique case (req.kind)
      OP_ADD: begin
        sr = sat_w(ar_e + br_e);
        si = sat_w(ai_e + bi_e);
      end
      OP_SUB: begin
        sr = sat_w(ar_e - br_e);
        si = sat_w(ai_e - bi_e);
      end
      OP_NEG: begin
        sr = sat_w(-ar_e);
        si = sat_w(-ai_e);
      end
      OP_CONJ: begin
        sr = {1'b0, req.a_real};
        si = sat_w(-ai_e);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
  end

  // The argument of a point on the imaginary axis is fixed; the CORDIC
  // carries it through unchanged.
  always_comb begin
    priority if (is_arg && ar_zero) begin
      if (req.a_imag > 0) begin
        z_init = HALF_PI_Q30;
      end else if (req.a_imag < 0) begin
        z_init = -HALF_PI_Q30;
      end else begin
        z_init = '0;
      end
    end else if (is_arg && ar_neg) begin
      z_init = req.a_imag[DW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      z_init = '0;
    end
  end

  logic                 s1_valid;
  logic [2:0]           s1_kind;
  logic signed [2*DW-1:0] p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;
  cau_rsp_t             s1_simple;
  logic signed [XW-1:0] c_x, c_y;
  logic signed [ZW-1:0] c_z;
  logic                 c_byp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_kind            <= req.kind;
    p_rr               <= req.a_real * req.b_real;
    p_ii               <= req.a_imag * req.b_imag;
    p_ri               <= req.a_real * req.b_imag;
    p_ir               <= req.a_imag * req.b_real;
    p_bbr              <= req.b_real * req.b_real;
    p_bbi              <= req.b_imag * req.b_imag;
    s1_simple.res_real <= sr[DW-1:0];
    s1_simple.res_imag <= si[DW-1:0];
    s1_simple.status   <= (sr[DW] || si[DW]) ? ST_SAT : ST_OK;
    c_x                <= XW'(x_src) <<< GUARD;
    c_y                <= XW'(y_src) <<< GUARD;
    c_z                <= z_init;
    c_byp              <= is_arg && ar_zero;
  end

  // ---------------- stage 2: sums, multiply result, divider operands -----
  logic signed [WIDE_W-1:0] mr_sum, mi_sum;
  logic [DW:0]              mr, mi;
  cau_ctrl_t                s2_next;

  assign mr_sum = WIDE_W'(p_rr) - WIDE_W'(p_ii);
  assign mi_sum = WIDE_W'(p_ri) + WIDE_W'(p_ir);
  assign mr     = sat_w(mr_sum >>> FB);
  assign mi     = sat_w(mi_sum >>> FB);

  always_comb begin
    s2_next.kind = s1_kind;
    if (s1_kind == OP_MUL) begin
      s2_next.val.res_real = mr[DW-1:0];
      s2_next.val.res_imag = mi[DW-1:0];
      s2_next.val.status   = (mr[DW] || mi[DW]) ? ST_SAT : ST_OK;
    end else begin
      s2_next.val = s1_simple;
    end
  end

  logic                    s2_valid;
  cau_ctrl_t               s2_ctrl;
  logic signed [NUM_W-1:0] num_r, num_i;
  logic [DEN_W-1:0]        den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ctrl <= s2_next;
    num_r   <= NUM_W'(p_rr) + NUM_W'(p_ii);
    num_i   <= NUM_W'(p_ir) - NUM_W'(p_ri);
    den     <= DEN_W'($unsigned(p_bbr)) + DEN_W'($unsigned(p_bbi));
  end

  // ---------------- long units -------------------------------------------
  logic [DW-1:0] q_r, q_i;
  logic          q_r_sat, q_i_sat, q_dz, q_dz_i;

  cau_div u_div_re (
    .clk (clk),
    .num (num_r),
    .den (den),
    .quo (q_r),
    .sat (q_r_sat),
    .dz  (q_dz)
  );

  cau_div u_div_im (
    .clk (clk),
    .num (num_i),
    .den (den),
    .quo (q_i),
    .sat (q_i_sat),
    .dz  (q_dz_i)
  );

  logic [DW-1:0] mod_val, arg_val;
  logic          mod_sat, arg_sat;

  cau_cordic u_cordic (
    .clk     (clk),
    .x0      (c_x),
    .y0      (c_y),
    .z0      (c_z),
    .byp     (c_byp),
    .mod_val (mod_val),
    .mod_sat (mod_sat),
    .arg_val (arg_val),
    .arg_sat (arg_sat)
  );

  // CORDIC results are ready earlier than the divider; align them.
  logic [DW-1:0] mod_d [PAD];
  logic [DW-1:0] arg_d [PAD];
  logic          mods_d [PAD];
  logic          args_d [PAD];

  always_ff @(posedge clk) begin
    mod_d[0]  <= mod_val;
    arg_d[0]  <= arg_val;
    mods_d[0] <= mod_sat;
    args_d[0] <= arg_sat;
    for (int k = 1; k < PAD; k++) begin
      mod_d[k]  <= mod_d[k-1];
      arg_d[k]  <= arg_d[k-1];
      mods_d[k] <= mods_d[k-1];
      args_d[k] <= args_d[k-1];
    end
  end

  // ---------------- control delay line -----------------------------------
  logic      d_valid [DIV_LAT];
  cau_ctrl_t d_ctrl  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        d_valid[k] <= 1'b0;
      end
    end else begin
      d_valid[0] <= s2_valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        d_valid[k] <= d_valid[k-1];
      end
    end
    d_ctrl[0] <= s2_ctrl;
    for (int k = 1; k < DIV_LAT; k++) begin
      d_ctrl[k] <= d_ctrl[k-1];
    end
  end

  // ---------------- result select ----------------------------------------
  cau_ctrl_t last;
  cau_rsp_t  rsp_next;

  assign last = d_ctrl[DIV_LAT-1];

  always_comb begin
    unique case (last.kind)
      OP_DIV: begin
        if (q_dz) begin
          rsp_next.res_real = '0;
          rsp_next.res_imag = '0;
          rsp_next.status   = ST_DIVZ;
        end else begin
          rsp_next.res_real = q_r;
          rsp_next.res_imag = q_i;
          rsp_next.status   = (q_r_sat || q_i_sat) ? ST_SAT : ST_OK;
        end
      end
      OP_MOD: begin
        rsp_next.res_real = mod_d[PAD-1];
        rsp_next.res_imag = '0;
        rsp_next.status   = mods_d[PAD-1] ? ST_SAT : ST_OK;
      end
      OP_ARG: begin
        rsp_next.res_real = arg_d[PAD-1];
        rsp_next.res_imag = '0;
        rsp_next.status   = args_d[PAD-1] ? ST_SAT : ST_OK;
      end
      default: begin
        rsp_next = last.val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid[DIV_LAT-1];
    end
    rsp <= rsp_next;
  end

  // Both dividers see the same divisor, so their zero flags agree.
  logic unused_dz;
  assign unused_dz = q_dz_i;

endmodule
`default_nettype wire
